// File: rtl/assert_macros.svh
// assertion helpers for the scheduler checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: rtl/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// shared constants and types of the dependency ready scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package drs_pkg;
   localparam int ENTRIES     = 64;
   localparam int MAX_DEPS    = 4;
   localparam int STREAM_BITS = 8;
   localparam int ID_BITS     = 6;
   localparam int TIME_BITS   = 64;
   localparam int DEP_FIELDS  = 4;

   localparam logic [1:0] FUNC_ADD      = 2'd0;
   localparam logic [1:0] FUNC_COMPLETE = 2'd1;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic          add;      // write the cell whose index matches id
      logic          complete; // mark executed and wake dependents
      logic [9:0]    id;
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/drs_cell.sv
// ----------------------------------------------------------------------------
// drs_cell
// one table entry: status, payload, dependency list, plus one step of the
// walk chain that hands on the running best, the next ready position and
// the ready and pending counts to its neighbour
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module drs_cell #(
   parameter int INDEX       = 0,
   parameter int IDX_BITS    = 6,
   parameter int MAX_DEPS    = 4,
   parameter int STREAM_BITS = 8
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire drs_pkg::cmd_type    cmd,
   input  wire                      cmd_valid,
   input  wire [7:0]                add_stream,
   input  wire [63:0]               add_time,
   input  wire [3:0]                add_cnt,
   input  wire [MAX_DEPS*6-1:0]     add_deps,
   // executed flags of ids, seen by every cell for its own deps
   input  wire [63:0]               exec_vec,
   output logic                     valid_o,
   output logic                     executed_o,
   // walk chain
   input  wire                      walk_i,
   output logic                     walk_o,
   input  wire [31:0]               order_i,
   output logic [31:0]              order_o,
   input  wire [6:0]                rtot_i,
   output logic [6:0]               rtot_o,
   input  wire [6:0]                ptot_i,
   output logic [6:0]               ptot_o,
   input  wire                      best_found_i,
   input  wire [63:0]               best_time_i,
   input  wire [31:0]               best_order_i,
   input  wire [IDX_BITS-1:0]       best_id_i,
   input  wire [STREAM_BITS-1:0]    best_stream_i,
   output logic                     best_found_o,
   output logic [63:0]              best_time_o,
   output logic [31:0]              best_order_o,
   output logic [IDX_BITS-1:0]      best_id_o,
   output logic [STREAM_BITS-1:0]   best_stream_o
);
   logic valid_ff, exec_ff, met_ff, ready_ff, wait_ff;
   logic [63:0] time_ff;
   logic [STREAM_BITS-1:0] stream_ff;
   logic [5:0] deps_ff [MAX_DEPS];
   logic [3:0] cnt_ff;
   logic [31:0] order_ff;
   logic walk_ff; logic [31:0] nord_ff; logic [6:0] rt_ff, pt_ff;
   logic bf_ff; logic [63:0] bt_ff; logic [31:0] bo_ff;
   logic [IDX_BITS-1:0] bi_ff; logic [STREAM_BITS-1:0] bs_ff;
   logic lists, all_exec, mine, make_ready, better;
   logic [31:0] my_order;

   assign mine = cmd.id == 10'(INDEX);
   always_comb begin
      lists = 1'b0;
      all_exec = 1'b1;
      for (int k = 0; k < MAX_DEPS; k++) begin
         if (4'(k) < cnt_ff) begin
            if (deps_ff[k] == cmd.id[5:0] && cmd.id < 10'd64) lists = 1'b1;
            if (!exec_vec[deps_ff[k]]) all_exec = 1'b0;
         end
      end
   end
   assign make_ready = cmd.complete && valid_ff && !met_ff && lists && all_exec;
   assign valid_o = valid_ff;
   assign executed_o = exec_ff;

   // wait_ff marks an entry made ready by this item; it takes its position
   // when the walk reaches it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; exec_ff <= 1'b0; met_ff <= 1'b0; ready_ff <= 1'b0;
         wait_ff <= 1'b0;
      end else if (cmd_valid) begin
         if (cmd.add && mine) begin
            valid_ff <= 1'b1; exec_ff <= 1'b0;
            met_ff <= add_cnt == 4'd0; ready_ff <= add_cnt == 4'd0;
            wait_ff <= add_cnt == 4'd0;
         end else if (cmd.complete) begin
            if (mine && valid_ff) exec_ff <= 1'b1;
            if (make_ready) begin
               met_ff <= 1'b1; ready_ff <= 1'b1; wait_ff <= 1'b1;
            end else if (mine && valid_ff) begin
               ready_ff <= 1'b0;
            end
         end
      end else if (walk_i) begin
         wait_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd_valid && cmd.add && mine) begin
         time_ff <= add_time;
         stream_ff <= add_stream[STREAM_BITS-1:0];
         cnt_ff <= add_cnt;
         for (int k = 0; k < MAX_DEPS; k++) deps_ff[k] <= add_deps[k*6 +: 6];
      end
      if (walk_i && wait_ff) order_ff <= order_i;
   end

   assign my_order = wait_ff ? order_i : order_ff;
   assign better = ready_ff && (!best_found_i || time_ff < best_time_i ||
      (time_ff == best_time_i && my_order < best_order_i));
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff <= 1'b0;
      end else begin
         walk_ff <= walk_i;
      end
   end
   always_ff @(posedge clock) begin
      if (walk_i) begin
         nord_ff <= order_i + 32'(wait_ff);
         rt_ff <= rtot_i + 7'(ready_ff);
         pt_ff <= ptot_i + 7'(valid_ff && !exec_ff);
         bf_ff <= best_found_i || ready_ff;
         bt_ff <= better ? time_ff : best_time_i;
         bo_ff <= better ? my_order : best_order_i;
         bi_ff <= better ? IDX_BITS'(INDEX) : best_id_i;
         bs_ff <= better ? stream_ff : best_stream_i;
      end
   end
   assign walk_o = walk_ff;
   assign order_o = nord_ff;
   assign rtot_o = rt_ff;
   assign ptot_o = pt_ff;
   assign best_found_o = bf_ff;
   assign best_time_o = bt_ff;
   assign best_order_o = bo_ff;
   assign best_id_o = bi_ff;
   assign best_stream_o = bs_ff;
endmodule
`default_nettype wire

// File: rtl/dependency_ready_scheduler.sv
// ----------------------------------------------------------------------------
// dependency_ready_scheduler
// table of operations with dependency wakeup and earliest-timestamp selection
// ----------------------------------------------------------------------------
// usage: raise start with the req_ fields while busy is low; the item is taken
// at that edge and busy rises. add (func 0) writes an entry, complete (func 1)
// marks it executed and wakes its dependents, any other func only queries.
// the cells form a chain; after the command cycle the walk passes one cell
// per cycle through every cell in turn, followed by the output state.
// busy stays high until the result appears, so a new item is taken only
// after the last one is done. the result appears on the rsp_ ports for
// one cycle with rsp_valid high; the receiver cannot stall it.
// newly ready entries take their positions as the walk reaches them, so
// positions follow index order; the walk also sums the ready and pending counts.
// reset clears all valid and status bits and the position counter; the
// block is ready for an item in the cycle after reset falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dependency_ready_scheduler #(
   parameter int ENTRIES     = drs_pkg::ENTRIES,
   parameter int MAX_DEPS    = drs_pkg::MAX_DEPS,
   parameter int STREAM_BITS = drs_pkg::STREAM_BITS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire [1:0]   req_func,
   input  wire [5:0]   req_op_id,
   input  wire [7:0]   req_stream_num,
   input  wire [63:0]  req_event_time,
   input  wire [2:0]   req_dep_count,
   input  wire [5:0]   req_dep_a,
   input  wire [5:0]   req_dep_b,
   input  wire [5:0]   req_dep_c,
   input  wire [5:0]   req_dep_d,
   output logic        rsp_valid,
   output logic        rsp_id_known,
   output logic        rsp_has_ready,
   output logic [5:0]  rsp_next_id,
   output logic [63:0] rsp_next_time,
   output logic [7:0]  rsp_next_stream,
   output logic [6:0]  rsp_ready_total,
   output logic [6:0]  rsp_pending_total,
   output logic        rsp_all_done
);
   localparam int IB = $clog2(ENTRIES);
   localparam int CB = $clog2(ENTRIES + 1);
   localparam int NC = ENTRIES < 64 ? ENTRIES : 64;

   typedef enum logic [1:0] {S_IDLE, S_CMD, S_WALK, S_OUT} state_type;
   state_type state_ff;
   drs_pkg::cmd_type cmd_ff;
   logic [7:0] stream_ff; logic [63:0] time_ff; logic [3:0] cnt_ff;
   logic [MAX_DEPS*6-1:0] deps_ff;
   logic known_ff;
   logic [31:0] order_ff;
   logic [CB-1:0] step_ff;

   logic [NC-1:0] vld, exe;
   logic [63:0] exec_vec;
   logic walk [NC+1]; logic [31:0] ord [NC+1];
   logic [6:0] rt [NC+1]; logic [6:0] pt [NC+1];
   logic bf [NC+1]; logic [63:0] bt [NC+1]; logic [31:0] bo [NC+1];
   logic [IB-1:0] bi [NC+1]; logic [STREAM_BITS-1:0] bs [NC+1];
   logic cmd_go, sel_step;
   logic [3:0] cnt_sat;
   logic [23:0] dep_all;

   assign cmd_go = state_ff == S_CMD;
   assign sel_step = state_ff == S_WALK;
   assign dep_all = {req_dep_d, req_dep_c, req_dep_b, req_dep_a};
   always_comb begin
      cnt_sat = {1'b0, req_dep_count};
      if (cnt_sat > 4'(MAX_DEPS)) cnt_sat = 4'(MAX_DEPS);
      if (cnt_sat > 4'(drs_pkg::DEP_FIELDS)) cnt_sat = 4'(drs_pkg::DEP_FIELDS);
   end
   // the completed id already counts as executed for its own wakeup
   always_comb begin
      exec_vec = '0;
      for (int i = 0; i < NC; i++)
         exec_vec[i] = vld[i] && (exe[i] ||
            (cmd_go && cmd_ff.complete && cmd_ff.id == 10'(i)));
   end

   assign walk[0] = sel_step && step_ff == '0;
   assign ord[0] = order_ff; assign rt[0] = '0; assign pt[0] = '0;
   assign bf[0] = 1'b0; assign bt[0] = '0; assign bo[0] = '0;
   assign bi[0] = '0;   assign bs[0] = '0;
   for (genvar g = 0; g < NC; g++) begin : g_cell
      // cell g reads its predecessor's registered outputs: a walk step per cycle
      drs_cell #(.INDEX(g), .IDX_BITS(IB), .MAX_DEPS(MAX_DEPS),
                 .STREAM_BITS(STREAM_BITS)) u_cell (
         .clock, .reset, .cmd(cmd_ff), .cmd_valid(cmd_go),
         .add_stream(stream_ff), .add_time(time_ff), .add_cnt(cnt_ff),
         .add_deps(deps_ff), .exec_vec(exec_vec),
         .valid_o(vld[g]), .executed_o(exe[g]),
         .walk_i(walk[g]), .walk_o(walk[g+1]), .order_i(ord[g]), .order_o(ord[g+1]),
         .rtot_i(rt[g]), .rtot_o(rt[g+1]), .ptot_i(pt[g]), .ptot_o(pt[g+1]),
         .best_found_i(bf[g]), .best_time_i(bt[g]),
         .best_order_i(bo[g]), .best_id_i(bi[g]), .best_stream_i(bs[g]),
         .best_found_o(bf[g+1]), .best_time_o(bt[g+1]), .best_order_o(bo[g+1]),
         .best_id_o(bi[g+1]), .best_stream_o(bs[g+1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; order_ff <= '0; rsp_valid <= 1'b0; step_ff <= '0;
      end else begin
         rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               state_ff <= S_CMD;
               cmd_ff.add <= req_func == drs_pkg::FUNC_ADD;
               cmd_ff.complete <= req_func == drs_pkg::FUNC_COMPLETE;
               cmd_ff.id <= {4'd0, req_op_id};
               stream_ff <= req_stream_num; time_ff <= req_event_time;
               cnt_ff <= cnt_sat; deps_ff <= dep_all[MAX_DEPS*6-1:0];
            end
            S_CMD: begin
               known_ff <= cmd_ff.complete && cmd_ff.id < 10'(NC) &&
                  vld[cmd_ff.id[IB-1:0]];
               step_ff <= '0;
               state_ff <= S_WALK;
            end
            S_WALK: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == CB'(NC - 1)) state_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               rsp_id_known <= known_ff;
               rsp_has_ready <= bf[NC];
               rsp_next_id <= bf[NC] ? 6'(bi[NC]) : 6'd0;
               rsp_next_time <= bf[NC] ? bt[NC] : 64'd0;
               rsp_next_stream <= bf[NC] ? 8'(bs[NC]) : 8'd0;
               rsp_ready_total <= rt[NC];
               rsp_pending_total <= pt[NC];
               rsp_all_done <= pt[NC] == 7'd0;
               order_ff <= ord[NC];
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
   assign busy = state_ff != S_IDLE;
endmodule
`default_nettype wire

// File: rtl/drs_checker.sv
// ----------------------------------------------------------------------------
// drs_checker
// port level checks of the scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module drs_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_valid,
   input wire        rsp_has_ready,
   input wire [6:0]  rsp_ready_total,
   input wire [6:0]  rsp_pending_total,
   input wire        rsp_all_done
);
   `ASSERT_NEXT(a_take, clock, reset, start && !busy, busy)
   `ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, !busy)
   `ASSERT_IMP(a_has, clock, reset, rsp_valid, rsp_has_ready == (rsp_ready_total != 7'd0))
   `ASSERT_IMP(a_done, clock, reset, rsp_valid, rsp_all_done == (rsp_pending_total == 7'd0))
endmodule
bind dependency_ready_scheduler drs_checker u_drs_checker (.*);
`default_nettype wire

// File: verif/dependency_ready_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_ready_scheduler_checker
// watches the command and result ports, keeps its own copy of the operation
// table, works out the answer to every accepted item and compares each
// result field by field with the oldest answer still awaited
// ----------------------------------------------------------------------------
module dependency_ready_scheduler_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire         busy,
   input  wire [1:0]   req_func,
   input  wire [5:0]   req_op_id,
   input  wire [7:0]   req_stream_num,
   input  wire [63:0]  req_event_time,
   input  wire [2:0]   req_dep_count,
   input  wire [5:0]   req_dep_a,
   input  wire [5:0]   req_dep_b,
   input  wire [5:0]   req_dep_c,
   input  wire [5:0]   req_dep_d,
   input  wire         rsp_valid,
   input  wire         rsp_id_known,
   input  wire         rsp_has_ready,
   input  wire [5:0]   rsp_next_id,
   input  wire [63:0]  rsp_next_time,
   input  wire [7:0]   rsp_next_stream,
   input  wire [6:0]   rsp_ready_total,
   input  wire [6:0]   rsp_pending_total,
   input  wire         rsp_all_done,
   output int          fail_count,
   output int          awaited_count
);
   localparam int ENTRIES  = drs_pkg::ENTRIES;
   localparam int MAX_DEPS = drs_pkg::MAX_DEPS;
   localparam logic [1:0] FUNC_ADD      = drs_pkg::FUNC_ADD;
   localparam logic [1:0] FUNC_COMPLETE = drs_pkg::FUNC_COMPLETE;

   typedef struct {
      bit        id_known;
      bit        has_ready;
      bit [5:0]  next_id;
      bit [63:0] next_time;
      bit [7:0]  next_stream;
      bit [6:0]  ready_total;
      bit [6:0]  pending_total;
      bit        all_done;
   } sched_answer_type;

   bit        op_valid   [ENTRIES];
   bit        op_done    [ENTRIES];
   bit        op_woken   [ENTRIES];
   bit        op_ready   [ENTRIES];
   bit [63:0] op_time    [ENTRIES];
   bit [7:0]  op_stream  [ENTRIES];
   bit [5:0]  op_deps    [ENTRIES][MAX_DEPS];
   bit [2:0]  op_ndeps   [ENTRIES];
   bit [31:0] op_pos     [ENTRIES];
   bit [31:0] next_pos;

   sched_answer_type answers_q[$];

   assign awaited_count = answers_q.size();

   task automatic put_on_ready(input int id);
      op_woken[id] = 1;
      op_ready[id] = 1;
      op_pos[id]   = next_pos;
      next_pos     = next_pos + 1;
   endtask

   task automatic wake_waiters(input bit [5:0] done_id);
      bit lists, all_met;
      for (int e = 0; e < ENTRIES; e++) begin
         if (!op_valid[e] || op_woken[e]) continue;
         lists   = 0;
         all_met = 1;
         for (int k = 0; k < op_ndeps[e]; k++) begin
            if (op_deps[e][k] == done_id) lists = 1;
            if (!(op_valid[op_deps[e][k]] && op_done[op_deps[e][k]])) all_met = 0;
         end
         if (lists && all_met) put_on_ready(e);
      end
   endtask

   task automatic schedule_item(output sched_answer_type ans);
      bit [2:0] n;
      bit [5:0] deps[4];
      bit       found;
      int       best;
      ans   = '{default: 0};
      found = 0;
      best  = 0;
      deps  = '{req_dep_a, req_dep_b, req_dep_c, req_dep_d};
      if (req_func == FUNC_ADD) begin
         n = (req_dep_count > MAX_DEPS) ? 3'(MAX_DEPS) : req_dep_count;
         op_valid[req_op_id]  = 1;
         op_done[req_op_id]   = 0;
         op_woken[req_op_id]  = 0;
         op_ready[req_op_id]  = 0;
         op_time[req_op_id]   = req_event_time;
         op_stream[req_op_id] = req_stream_num;
         op_ndeps[req_op_id]  = n;
         for (int k = 0; k < n; k++) op_deps[req_op_id][k] = deps[k];
         if (n == 0) put_on_ready(req_op_id);
      end else if (req_func == FUNC_COMPLETE && op_valid[req_op_id]) begin
         ans.id_known        = 1;
         op_done[req_op_id]  = 1;
         op_ready[req_op_id] = 0;
         wake_waiters(req_op_id);
      end
      ans.all_done = 1;
      for (int e = 0; e < ENTRIES; e++) begin
         if (op_valid[e] && !op_done[e]) begin
            ans.pending_total++;
            ans.all_done = 0;
         end
         if (!op_ready[e]) continue;
         ans.ready_total++;
         if (!found || op_time[e] < op_time[best] ||
             (op_time[e] == op_time[best] && op_pos[e] < op_pos[best])) begin
            found = 1;
            best  = e;
         end
      end
      if (found) begin
         ans.has_ready   = 1;
         ans.next_id     = best[5:0];
         ans.next_time   = op_time[best];
         ans.next_stream = op_stream[best];
      end
   endtask

   task automatic report(input string what, input bit [63:0] got, input bit [63:0] want);
      $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      sched_answer_type a, w;
      if (reset) begin
         foreach (op_valid[e]) begin
            op_valid[e] = 0;
            op_done[e]  = 0;
            op_woken[e] = 0;
            op_ready[e] = 0;
         end
         next_pos = 0;
         answers_q.delete();
      end else begin
         // results first, so an answer is never compared with a newer item
         if (rsp_valid) begin
            if (answers_q.size() == 0) begin
               report("unexpected result", rsp_next_id, 0);
            end else begin
               w = answers_q.pop_front();
               if (rsp_id_known != w.id_known) report("id_known", rsp_id_known, w.id_known);
               if (rsp_has_ready != w.has_ready)
                  report("has_ready", rsp_has_ready, w.has_ready);
               if (rsp_next_id != w.next_id) report("next_id", rsp_next_id, w.next_id);
               if (rsp_next_time != w.next_time)
                  report("next_time", rsp_next_time, w.next_time);
               if (rsp_next_stream != w.next_stream)
                  report("next_stream", rsp_next_stream, w.next_stream);
               if (rsp_ready_total != w.ready_total)
                  report("ready_total", rsp_ready_total, w.ready_total);
               if (rsp_pending_total != w.pending_total)
                  report("pending_total", rsp_pending_total, w.pending_total);
               if (rsp_all_done != w.all_done) report("all_done", rsp_all_done, w.all_done);
            end
         end
         if (start && !busy) begin
            schedule_item(a);
            answers_q = {answers_q, a};
         end
      end
   end
endmodule

// File: verif/dependency_ready_scheduler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_ready_scheduler_tb
// drives directed and random add, complete and query items in bursts and
// leaves prediction and comparison to the checker beside the block
// ----------------------------------------------------------------------------
module dependency_ready_scheduler_tb;
   localparam int ENTRIES = drs_pkg::ENTRIES;
   localparam logic [1:0] FUNC_ADD      = drs_pkg::FUNC_ADD;
   localparam logic [1:0] FUNC_COMPLETE = drs_pkg::FUNC_COMPLETE;
   localparam logic [1:0] FUNC_QUERY = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;
   localparam int RANDOM_ITEMS = 1680;
   localparam int CYCLE_LIMIT  = 800000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   wire         busy;
   logic [1:0]  req_func = 0;
   logic [5:0]  req_op_id = 0;
   logic [7:0]  req_stream_num = 0;
   logic [63:0] req_event_time = 0;
   logic [2:0]  req_dep_count = 0;
   logic [5:0]  req_dep_a = 0, req_dep_b = 0, req_dep_c = 0, req_dep_d = 0;
   wire         rsp_valid, rsp_id_known, rsp_has_ready, rsp_all_done;
   wire [5:0]   rsp_next_id;
   wire [63:0]  rsp_next_time;
   wire [7:0]   rsp_next_stream;
   wire [6:0]   rsp_ready_total, rsp_pending_total;
   int          fail_count, awaited_count;
   int          cycles = 0;

   bit          added[ENTRIES];
   int          added_ids[$];

   always #10 clock = ~clock;

   dependency_ready_scheduler dut (.*);
   dependency_ready_scheduler_checker chk (.*);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // holds the item until the block takes it; start stays high afterwards
   task automatic send(input logic [1:0] f, input logic [5:0] id, input logic [7:0] s,
                       input logic [63:0] t, input logic [2:0] n, input logic [5:0] a,
                       input logic [5:0] b, input logic [5:0] c, input logic [5:0] d);
      @(negedge clock);
      req_func = f; req_op_id = id; req_stream_num = s; req_event_time = t;
      req_dep_count = n; req_dep_a = a; req_dep_b = b; req_dep_c = c; req_dep_d = d;
      start = 1;
      do @(posedge clock); while (busy);
      if (f == FUNC_ADD && !added[id]) begin
         added[id] = 1;
         added_ids = {added_ids, int'(id)};
      end
   endtask

   task automatic gap(input int n);
      @(negedge clock);
      start = 0;
      repeat (n) @(negedge clock);
   endtask

   function automatic logic [5:0] pick_known();
      if (added_ids.size() == 0 || $urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
      return 6'(added_ids[$urandom_range(0, added_ids.size() - 1)]);
   endfunction

   function automatic logic [63:0] pick_time();
      case ($urandom_range(0, 3))
         0: return {$urandom, $urandom};
         default: return 64'($urandom_range(0, 15));
      endcase
   endfunction

   initial begin
      int burst;
      logic [1:0] f;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: empty table, extremes, ties, dependency corner cases
      send(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_COMPLETE, 17, 0, 0, 0, 0, 0, 0, 0);        // complete of nothing stored
      send(FUNC_ADD, 63, 8'hff, '1, 0, 0, 0, 0, 0);
      send(FUNC_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_ADD, 1, 8'h5a, 0, 0, 0, 0, 0, 0);           // timestamp tie, later position
      send(FUNC_ADD, 2, 8'ha5, 64'h10, 7, 0, 1, 63, 40);     // dep_count above limit, unknown dep
      send(FUNC_ADD, 3, 8'h33, 64'h8, 1, 3, 0, 0, 0);       // self dependency
      send(FUNC_ADD, 4, 8'h44, 64'h4, 2, 0, 1, 0, 0);
      send(FUNC_COMPLETE, 4, 0, 0, 0, 0, 0, 0, 0);          // completed before its deps
      send(FUNC_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_COMPLETE, 1, 0, 0, 0, 0, 0, 0, 0);          // wakes the executed entry
      send(FUNC_COMPLETE, 4, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_COMPLETE, 4, 0, 0, 0, 0, 0, 0, 0);          // repeated complete
      send(FUNC_COMPLETE, 3, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_SPARE, 9, 8'hff, '1, 7, 63, 63, 63, 63);
      send(FUNC_ADD, 1, 8'h11, 64'h2, 1, 63, 0, 0, 0);       // re-add with a dependency
      send(FUNC_ADD, 0, 8'h22, 64'h3, 0, 0, 0, 0, 0);       // re-add, fresh position
      send(FUNC_COMPLETE, 63, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_COMPLETE, 40, 0, 0, 0, 0, 0, 0, 0);
      send(FUNC_COMPLETE, 2, 0, 0, 0, 0, 0, 0, 0);
      gap(2);
      wait (awaited_count == 0);

      for (int i = 0; i < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 20);
         for (int j = 0; j < burst; j++, i++) begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7: f = FUNC_ADD;
               8, 9, 10, 11, 12, 13, 14, 15, 16: f = FUNC_COMPLETE;
               17, 18: f = FUNC_QUERY;
               default: f = FUNC_SPARE;
            endcase
            send(f, (f == FUNC_ADD) ? 6'($urandom_range(0, 63)) : pick_known(),
                 8'($urandom), pick_time(),
                 ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4)),
                 pick_known(), pick_known(), pick_known(), pick_known());
         end
         if (i % 400 < burst) begin
            gap(1);
            wait (awaited_count == 0);
         end else if ($urandom_range(0, 2) != 0) begin
            gap($urandom_range(0, 80));
         end
      end
      gap(1);
      wait (awaited_count == 0);
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
